[sv/rea_pkg.sv]
`timescale 1ns / 1ps

package rea_pkg;

  localparam int unsigned CoordW   = 32;
  localparam int unsigned RotW     = 20;
  localparam int unsigned RowW     = 3 * RotW;
  localparam int unsigned DiffW    = 42;
  localparam int unsigned QW       = 48;
  localparam int unsigned MulAW    = 43;
  localparam int unsigned MulBW    = 33;
  localparam int unsigned ProdW    = MulAW + MulBW;
  localparam int unsigned AccW     = 64;
  localparam int unsigned QuoW     = 34;
  localparam int unsigned SumW     = 48;
  localparam int unsigned OutCntW  = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned StepW    = 6;
  localparam int unsigned IdxW     = 4;

  localparam logic [StepW-1:0] DivLast  = StepW'(QuoW - 1);
  localparam logic [StepW-1:0] SqrtLast = StepW'(31);

  localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] RegRot0  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegRot1  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegRot2  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegTx    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegTy    = 3'd4;
  localparam logic [CfgIdxW-1:0] RegTz    = 3'd5;

  localparam logic [RowW-1:0] Rot0Reset = RowW'(64'd1 << 40);
  localparam logic [RowW-1:0] Rot1Reset = RowW'(64'd1 << 20);
  localparam logic [RowW-1:0] Rot2Reset = RowW'(1);

  typedef struct packed {
    logic signed [CoordW-1:0] src_x;
    logic signed [CoordW-1:0] src_y;
    logic signed [CoordW-1:0] src_depth;
    logic signed [CoordW-1:0] obs_x;
    logic signed [CoordW-1:0] obs_y;
    logic                     last_pair;
  } rea_in_t;

  typedef struct packed {
    logic [SumW-1:0]    error_total;
    logic [OutCntW-1:0] pair_count;
    logic               depth_fault;
    logic               sum_saturated;
  } rea_out_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_P,
    OP_ACC_P,
    OP_MUL_R,
    OP_ACC_R,
    OP_RND_Q,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_END,
    OP_MUL_SQ,
    OP_ACC_SQ,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_UPDATE
  } rea_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_P,
    ST_ACC_P,
    ST_MUL_R,
    ST_ACC_R,
    ST_RND_Q,
    ST_CHECK,
    ST_DIV_INIT,
    ST_DIV_STEP,
    ST_DIV_END,
    ST_MUL_SQ,
    ST_ACC_SQ,
    ST_SQRT_INIT,
    ST_SQRT_STEP,
    ST_UPDATE
  } rea_state_e;

  typedef struct packed {
    rea_op_e         op;
    logic [IdxW-1:0] idx;
  } rea_cmd_t;

  typedef struct packed {
    logic depth_bad;
    logic out_block;
  } rea_status_t;

endpackage

[sv/rea_ctrl.sv]
`timescale 1ns / 1ps

module rea_ctrl import rea_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  rea_status_t status_i,
  output rea_cmd_t    cmd_o
);

  rea_state_e       state_q, state_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic [StepW-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
    end
  end

  // idx holds {column, row} in the rotation loop, x or y elsewhere
  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    cnt_d      = cnt_q;
    in_ready_o = 1'b0;
    cmd_o.op   = OP_NONE;
    cmd_o.idx  = idx_q;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          idx_d    = '0;
          state_d  = ST_MUL_P;
        end
      end
      ST_MUL_P: begin
        cmd_o.op = OP_MUL_P;
        state_d  = ST_ACC_P;
      end
      ST_ACC_P: begin
        cmd_o.op = OP_ACC_P;
        if (idx_q[0]) begin
          idx_d   = '0;
          state_d = ST_MUL_R;
        end else begin
          idx_d   = IdxW'(1);
          state_d = ST_MUL_P;
        end
      end
      ST_MUL_R: begin
        cmd_o.op = OP_MUL_R;
        state_d  = ST_ACC_R;
      end
      ST_ACC_R: begin
        cmd_o.op = OP_ACC_R;
        if (idx_q[1:0] == 2'd2) begin
          state_d = ST_RND_Q;
        end else begin
          idx_d   = {idx_q[3:2], idx_q[1:0] + 2'd1};
          state_d = ST_MUL_R;
        end
      end
      ST_RND_Q: begin
        cmd_o.op = OP_RND_Q;
        if (idx_q[3:2] == 2'd2) begin
          state_d = ST_CHECK;
        end else begin
          idx_d   = {idx_q[3:2] + 2'd1, 2'd0};
          state_d = ST_MUL_R;
        end
      end
      ST_CHECK: begin
        idx_d   = '0;
        state_d = status_i.depth_bad ? ST_UPDATE : ST_DIV_INIT;
      end
      ST_DIV_INIT: begin
        cmd_o.op = OP_DIV_INIT;
        cnt_d    = '0;
        state_d  = ST_DIV_STEP;
      end
      ST_DIV_STEP: begin
        cmd_o.op = OP_DIV_STEP;
        cnt_d    = cnt_q + StepW'(1);
        if (cnt_q == DivLast) begin
          state_d = ST_DIV_END;
        end
      end
      ST_DIV_END: begin
        cmd_o.op = OP_DIV_END;
        if (idx_q[0]) begin
          idx_d   = '0;
          state_d = ST_MUL_SQ;
        end else begin
          idx_d   = IdxW'(1);
          state_d = ST_DIV_INIT;
        end
      end
      ST_MUL_SQ: begin
        cmd_o.op = OP_MUL_SQ;
        state_d  = ST_ACC_SQ;
      end
      ST_ACC_SQ: begin
        cmd_o.op = OP_ACC_SQ;
        if (idx_q[0]) begin
          state_d = ST_SQRT_INIT;
        end else begin
          idx_d   = IdxW'(1);
          state_d = ST_MUL_SQ;
        end
      end
      ST_SQRT_INIT: begin
        cmd_o.op = OP_SQRT_INIT;
        cnt_d    = '0;
        state_d  = ST_SQRT_STEP;
      end
      ST_SQRT_STEP: begin
        cmd_o.op = OP_SQRT_STEP;
        cnt_d    = cnt_q + StepW'(1);
        if (cnt_q == SqrtLast) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (!status_i.out_block) begin
          cmd_o.op = OP_UPDATE;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

[sv/rea_datapath.sv]
`timescale 1ns / 1ps

module rea_datapath import rea_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rea_cmd_t            cmd_i,
  output rea_status_t         status_o,
  input  rea_in_t             in_data_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [RowW-1:0]     cfg_wdata_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rea_out_t            out_data_o
);

  // configuration
  logic [RowW-1:0]          rot_q [3];
  logic signed [CoordW-1:0] trans_q [3];

  // item and working registers
  rea_in_t                  item_q;
  logic signed [DiffW-1:0]  d_q [3];
  logic signed [ProdW-1:0]  mul_q;
  logic signed [AccW-1:0]   acc_q;
  logic signed [QW-1:0]     q_q [3];
  logic [QW-1:0]            rem_q;
  logic [QuoW-1:0]          numlo_q;
  logic [QuoW-1:0]          quo_q;
  logic                     ovf_q;
  logic                     neg_q;
  logic [CoordW-1:0]        abs_q [2];
  logic [AccW-1:0]          sq_q;
  logic [AccW-1:0]          rt_q;
  logic [AccW-1:0]          bit_q;

  // accumulation state
  logic [SumW-1:0]          sum_q;
  logic [COUNT_WIDTH-1:0]   items_q;
  logic                     fault_q;
  logic                     sat_q;
  logic                     out_valid_q;
  rea_out_t                 out_q;

  logic [1:0]               r_sel;
  logic [1:0]               c_sel;
  logic signed [MulAW-1:0]  mul_a;
  logic signed [MulBW-1:0]  mul_b;
  logic signed [RotW-1:0]   rot_ent;
  logic signed [ProdW-1:0]  p_rnd;
  logic signed [ProdW-1:0]  p_diff;
  logic signed [DiffW-1:0]  p_clamp;
  logic signed [CoordW+1:0] dz;
  logic signed [AccW-1:0]   acc_new;
  logic signed [AccW-1:0]   q_rnd;
  logic signed [QW-1:0]     qsel;
  logic [QW-1:0]            qmag;
  logic [AccW-1:0]          num;
  logic [QW:0]              rem_t;
  logic [QuoW:0]            u_mag;
  logic signed [QuoW+1:0]   u_s;
  logic signed [QuoW+2:0]   e_s;
  logic signed [QuoW+2:0]   obs_s;
  logic [CoordW-1:0]        e_abs;
  logic [AccW-1:0]          sq_try;
  logic [AccW-1:0]          len;
  logic [SumW:0]            sum_new;
  logic [SumW-1:0]          sum_upd;
  logic                     sat_upd;
  logic                     fault_upd;
  logic [COUNT_WIDTH-1:0]   items_upd;

  assign r_sel = cmd_i.idx[1:0];
  assign c_sel = cmd_i.idx[3:2];

  assign status_o.depth_bad = (q_q[2] <= 0);
  assign status_o.out_block = item_q.last_pair && out_valid_q && !out_ready_i;

  // rotation entry: column 0 sits in the top bits
  always_comb begin
    case (c_sel)
      2'd0:    rot_ent = rot_q[r_sel][3*RotW-1:2*RotW];
      2'd1:    rot_ent = rot_q[r_sel][2*RotW-1:RotW];
      default: rot_ent = rot_q[r_sel][RotW-1:0];
    endcase
  end

  // shared multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      OP_MUL_P: begin
        mul_a = MulAW'(item_q.src_depth);
        mul_b = cmd_i.idx[0] ? MulBW'(item_q.src_y) : MulBW'(item_q.src_x);
      end
      OP_MUL_R: begin
        mul_a = MulAW'(d_q[r_sel]);
        mul_b = MulBW'(rot_ent);
      end
      OP_MUL_SQ: begin
        mul_a = $signed({{(MulAW-CoordW){1'b0}}, abs_q[cmd_i.idx[0]]});
        mul_b = $signed({1'b0, abs_q[cmd_i.idx[0]]});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // scaled point minus translation, clamped to the difference range
  always_comb begin
    p_rnd  = (mul_q + ProdW'(32768)) >>> 16;
    p_diff = p_rnd - ProdW'(trans_q[cmd_i.idx[0]]);
    if (p_diff > $signed(ProdW'({1'b0, {(DiffW-1){1'b1}}}))) begin
      p_clamp = {1'b0, {(DiffW-1){1'b1}}};
    end else if (p_diff < -(ProdW'(64'sd1) <<< (DiffW-1))) begin
      p_clamp = {1'b1, {(DiffW-1){1'b0}}};
    end else begin
      p_clamp = DiffW'(p_diff);
    end
  end

  assign dz      = (CoordW+2)'(in_data_i.src_depth) - (CoordW+2)'(trans_q[2]);
  assign acc_new = ((r_sel == 2'd0) ? '0 : acc_q) + AccW'(mul_q);
  assign q_rnd   = (acc_q + AccW'(131072)) >>> 18;

  // divider setup on the magnitude of the numerator
  assign qsel  = q_q[cmd_i.idx[0]];
  assign qmag  = qsel[QW-1] ? QW'(-qsel) : QW'(qsel);
  assign num   = AccW'(qmag) << 16;
  assign rem_t = {rem_q, numlo_q[QuoW-1]};

  // quotient past 2^34 clamps the residual anyway
  always_comb begin
    u_mag = ovf_q ? (QuoW+1)'(1) << QuoW : {1'b0, quo_q};
    u_s   = neg_q ? -$signed({1'b0, u_mag}) : $signed({1'b0, u_mag});
    obs_s = cmd_i.idx[0] ? (QuoW+3)'(item_q.obs_y) : (QuoW+3)'(item_q.obs_x);
    e_s   = (QuoW+3)'(u_s) - obs_s;
    if (e_s >= (QuoW+3)'(64'sd2147483648)) begin
      e_abs = CoordW'(64'd2147483648);
    end else if (e_s <= -(QuoW+3)'(64'sd2147483648)) begin
      e_abs = CoordW'(64'd2147483648);
    end else if (e_s < 0) begin
      e_abs = CoordW'(-e_s);
    end else begin
      e_abs = CoordW'(e_s);
    end
  end

  assign sq_try = rt_q + bit_q;

  // end of item: count, accumulate, flag
  always_comb begin
    len       = status_o.depth_bad ? '0 : rt_q;
    sum_new   = {1'b0, sum_q} + (SumW+1)'(len);
    sum_upd   = sum_q;
    sat_upd   = sat_q;
    fault_upd = fault_q || status_o.depth_bad;
    items_upd = (items_q == {COUNT_WIDTH{1'b1}}) ? items_q : items_q + COUNT_WIDTH'(1);
    if (!status_o.depth_bad) begin
      if (sum_new >= (SumW+1)'(SumMax)) begin
        sum_upd = SumMax;
        sat_upd = 1'b1;
      end else begin
        sum_upd = SumW'(sum_new);
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q[0]   <= Rot0Reset;
      rot_q[1]   <= Rot1Reset;
      rot_q[2]   <= Rot2Reset;
      trans_q[0] <= '0;
      trans_q[1] <= '0;
      trans_q[2] <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegRot0: rot_q[0]   <= cfg_wdata_i;
        RegRot1: rot_q[1]   <= cfg_wdata_i;
        RegRot2: rot_q[2]   <= cfg_wdata_i;
        RegTx:   trans_q[0] <= cfg_wdata_i[CoordW-1:0];
        RegTy:   trans_q[1] <= cfg_wdata_i[CoordW-1:0];
        RegTz:   trans_q[2] <= cfg_wdata_i[CoordW-1:0];
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        item_q <= in_data_i;
        d_q[2] <= DiffW'(dz);
      end
      OP_MUL_P, OP_MUL_R, OP_MUL_SQ: begin
        mul_q <= mul_a * mul_b;
      end
      OP_ACC_P: begin
        d_q[cmd_i.idx[0]] <= p_clamp;
      end
      OP_ACC_R: begin
        acc_q <= acc_new;
      end
      OP_RND_Q: begin
        q_q[c_sel] <= QW'(q_rnd);
      end
      OP_DIV_INIT: begin
        neg_q   <= qsel[QW-1];
        ovf_q   <= (QW'(num[AccW-1:QuoW]) >= q_q[2]);
        rem_q   <= QW'(num[AccW-1:QuoW]);
        numlo_q <= num[QuoW-1:0];
        quo_q   <= '0;
      end
      OP_DIV_STEP: begin
        numlo_q <= numlo_q << 1;
        if (rem_t >= (QW+1)'(q_q[2])) begin
          rem_q <= QW'(rem_t - (QW+1)'(q_q[2]));
          quo_q <= {quo_q[QuoW-2:0], 1'b1};
        end else begin
          rem_q <= QW'(rem_t);
          quo_q <= {quo_q[QuoW-2:0], 1'b0};
        end
      end
      OP_DIV_END: begin
        abs_q[cmd_i.idx[0]] <= e_abs;
      end
      OP_ACC_SQ: begin
        sq_q <= (cmd_i.idx[0] ? sq_q : '0) + AccW'(mul_q);
      end
      OP_SQRT_INIT: begin
        rt_q  <= '0;
        bit_q <= AccW'(1) << (AccW-2);
      end
      OP_SQRT_STEP: begin
        bit_q <= bit_q >> 2;
        if (sq_q >= sq_try) begin
          sq_q <= sq_q - sq_try;
          rt_q <= (rt_q >> 1) + bit_q;
        end else begin
          rt_q <= rt_q >> 1;
        end
      end
      default: ;
    endcase
  end

  // accumulation state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      items_q     <= '0;
      fault_q     <= 1'b0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.op == OP_UPDATE) begin
        if (item_q.last_pair) begin
          sum_q       <= '0;
          items_q     <= '0;
          fault_q     <= 1'b0;
          sat_q       <= 1'b0;
          out_valid_q <= 1'b1;
        end else begin
          sum_q   <= sum_upd;
          items_q <= items_upd;
          fault_q <= fault_upd;
          sat_q   <= sat_upd;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_UPDATE && item_q.last_pair) begin
      out_q.error_total   <= sum_upd;
      out_q.pair_count    <= OutCntW'(items_upd);
      out_q.depth_fault   <= fault_upd;
      out_q.sum_saturated <= sat_upd;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[sv/reprojection_error_accumulator_unit.sv]
`timescale 1ns / 1ps

// channel | direction | handshake              | payload
// input   | in        | in_valid_i / in_ready_o   | in_data_i (rea_in_t)
// result  | out       | out_valid_o / out_ready_i | out_data_o (rea_out_t)
// config  | in        | cfg_we_i, no wait         | cfg_idx_i, cfg_wdata_i
//
// one item runs 13 multiplies through one shared multiplier, each followed by its
// ACC step, two 34-step restoring divisions and a 32-step square root
// an item whose projected depth is not positive skips division and root
// reset clears control, accumulation state and loads the raw-1 diagonal rotation
// a finished result sits in the output register; only a closing item stalls on it

module reprojection_error_accumulator_unit import rea_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rea_in_t            in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rea_out_t           out_data_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [RowW-1:0]    cfg_wdata_i
);

  // command and status between sequencer and datapath
  rea_cmd_t    cmd;
  rea_status_t status;

  rea_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // datapath holds config, working registers, sum state and the result register
  rea_datapath #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

[sim/reprojection_error_accumulator_checker.sv]
`timescale 1ns / 1ps

module reprojection_error_accumulator_checker import rea_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  rea_in_t            in_data_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  rea_out_t           out_data_i,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [RowW-1:0]    cfg_wdata_i,
  output int                 fail_count_o,
  output int                 totals_pending_o,
  output int                 totals_checked_o,
  output int                 faults_seen_o
);

  logic [RowW-1:0]          rot_row [3];
  logic signed [CoordW-1:0] trans [3];
  logic [SumW-1:0]          err_sum;
  logic [15:0]              pairs_seen;
  logic                     fault_flag;
  logic                     sat_flag;
  rea_out_t                 expected_totals [$];

  function automatic longint round_shift(input longint v, input int s);
    round_shift = (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    clamp = (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] n);
    logic [63:0] r;
    logic [63:0] b;
    r = '0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    int_sqrt = r;
  endfunction

  // folds one correspondence into the running sum, returns 1 when a total closes
  function automatic bit accumulate_pair(input rea_in_t it, output rea_out_t total);
    longint p [3];
    longint d [3];
    longint q [3];
    longint acc;
    longint u;
    longint v;
    longint ex;
    longint ey;
    logic signed [RotW-1:0] e;
    logic [63:0] len;
    logic [63:0] s;
    p[0] = round_shift(longint'(it.src_x) * longint'(it.src_depth), 16);
    p[1] = round_shift(longint'(it.src_y) * longint'(it.src_depth), 16);
    p[2] = longint'(it.src_depth);
    for (int r = 0; r < 3; r++) begin
      d[r] = clamp(p[r] - longint'(trans[r]), -(longint'(1) << 41), (longint'(1) << 41) - 1);
    end
    for (int c = 0; c < 3; c++) begin
      acc = 0;
      for (int r = 0; r < 3; r++) begin
        e = rot_row[r][(2 - c) * RotW +: RotW];
        acc += longint'(e) * d[r];
      end
      q[c] = round_shift(acc, 18);
    end
    if (pairs_seen != 16'hffff) pairs_seen++;
    if (q[2] <= 0) begin
      fault_flag = 1'b1;
    end else begin
      u = (q[0] * 65536) / q[2];
      v = (q[1] * 65536) / q[2];
      ex = clamp(u - longint'(it.obs_x), -(longint'(1) << 31), longint'(1) << 31);
      ey = clamp(v - longint'(it.obs_y), -(longint'(1) << 31), longint'(1) << 31);
      if (ex < 0) ex = -ex;
      if (ey < 0) ey = -ey;
      len = int_sqrt(64'(ex) * 64'(ex) + 64'(ey) * 64'(ey));
      s = 64'(err_sum) + len;
      if (s >= 64'(SumMax)) begin
        s = 64'(SumMax);
        sat_flag = 1'b1;
      end
      err_sum = s[SumW-1:0];
    end
    total = '0;
    if (!it.last_pair) return 1'b0;
    total.error_total   = err_sum;
    total.pair_count    = pairs_seen;
    total.depth_fault   = fault_flag;
    total.sum_saturated = sat_flag;
    err_sum = '0;
    pairs_seen = '0;
    fault_flag = 1'b0;
    sat_flag = 1'b0;
    return 1'b1;
  endfunction

  assign totals_pending_o = expected_totals.size();

  always @(posedge clk_i or negedge rst_ni) begin
    rea_out_t want;
    rea_out_t got;
    if (!rst_ni) begin
      rot_row[0] = Rot0Reset;
      rot_row[1] = Rot1Reset;
      rot_row[2] = Rot2Reset;
      for (int i = 0; i < 3; i++) trans[i] = '0;
      err_sum = '0;
      pairs_seen = '0;
      fault_flag = 1'b0;
      sat_flag = 1'b0;
      expected_totals.delete();
      fail_count_o <= 0;
      totals_checked_o <= 0;
      faults_seen_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegRot0: rot_row[0] = cfg_wdata_i;
          RegRot1: rot_row[1] = cfg_wdata_i;
          RegRot2: rot_row[2] = cfg_wdata_i;
          RegTx:   trans[0] = cfg_wdata_i[CoordW-1:0];
          RegTy:   trans[1] = cfg_wdata_i[CoordW-1:0];
          RegTz:   trans[2] = cfg_wdata_i[CoordW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        if (accumulate_pair(in_data_i, want)) begin
          expected_totals.insert(expected_totals.size(), want);
        end
      end
      if (out_valid_i && out_ready_i) begin
        got = out_data_i;
        if (expected_totals.size() == 0) begin
          $display("%0t: unexpected total %h", $time, got);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_totals.pop_front();
          totals_checked_o <= totals_checked_o + 1;
          if (want.depth_fault) faults_seen_o <= faults_seen_o + 1;
          if (got !== want) begin
            $display("%0t: total mismatch expected sum=%h cnt=%0d flt=%b sat=%b",
                     $time, want.error_total, want.pair_count, want.depth_fault,
                     want.sum_saturated);
            $display("%0t:                actual   sum=%h cnt=%0d flt=%b sat=%b",
                     $time, got.error_total, got.pair_count, got.depth_fault,
                     got.sum_saturated);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

[sim/reprojection_error_accumulator_unit_test.sv]
`timescale 1ns / 1ps

module reprojection_error_accumulator_unit_test;
  import rea_pkg::*;

  localparam int unsigned StallLimit = 4000;
  // let a late non-closing item drain
  localparam int unsigned DrainCycles = 300;
  localparam int unsigned Q18One = 1 << 18;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  rea_in_t            in_data;
  logic               out_valid;
  logic               out_ready;
  rea_out_t           out_data;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [RowW-1:0]    cfg_wdata;

  int fail_count;
  int totals_pending;
  int totals_checked;
  int faults_seen;
  int pairs_sent;
  int idle_cycles;
  bit calm;

  reprojection_error_accumulator_unit u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  reprojection_error_accumulator_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .in_data_i       (in_data),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .out_data_i      (out_data),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .fail_count_o    (fail_count),
    .totals_pending_o(totals_pending),
    .totals_checked_o(totals_checked),
    .faults_seen_o   (faults_seen)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int k;
    if (calm) return 0;
    k = $urandom_range(0, 99);
    if (k < 60) return 0;
    if (k < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 150);
  endfunction

  // result side back-pressure, independent of the sender
  initial begin
    int low;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(negedge clk);
      low = pick_gap();
      if (low > 0) begin
        out_ready <= 1'b0;
        repeat (low) @(negedge clk);
      end
    end
  end

  // watchdog: too long without any transfer on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [RowW-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic end_cfg();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [RowW-1:0] pack_row(input int a, input int b, input int c);
    pack_row = {RotW'(a), RotW'(b), RotW'(c)};
  endfunction

  task automatic load_pose(input logic [RowW-1:0] r0, input logic [RowW-1:0] r1,
                           input logic [RowW-1:0] r2, input int tx, input int ty,
                           input int tz);
    write_reg(RegRot0, r0);
    write_reg(RegRot1, r1);
    write_reg(RegRot2, r2);
    write_reg(RegTx, RowW'(tx));
    write_reg(RegTy, RowW'(ty));
    write_reg(RegTz, RowW'(tz));
    end_cfg();
  endtask

  // near-rotation with small off-diagonal terms, or pure noise
  task automatic load_random_pose();
    logic [RowW-1:0] r [3];
    int t [3];
    for (int i = 0; i < 3; i++) begin
      if ($urandom_range(0, 5) == 0) begin
        r[i] = RowW'({$urandom, $urandom});
      end else begin
        r[i] = '0;
        for (int c = 0; c < 3; c++) begin
          if (c == i)
            r[i][(2 - c) * RotW +: RotW] = RotW'(Q18One + $urandom_range(0, 40000) - 20000);
          else
            r[i][(2 - c) * RotW +: RotW] = RotW'($urandom_range(0, 80000) - 40000);
        end
      end
      t[i] = ($urandom_range(0, 7) == 0) ? int'($urandom) : $urandom_range(0, 1 << 19) - (1 << 18);
    end
    load_pose(r[0], r[1], r[2], t[0], t[1], t[2]);
  endtask

  task automatic send_pair(input rea_in_t it);
    int gap;
    gap = pick_gap();
    repeat (gap) @(negedge clk);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    pairs_sent++;
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // plausible geometry most of the time, raw 32-bit noise otherwise
  function automatic rea_in_t random_pair(input bit last);
    rea_in_t it;
    if ($urandom_range(0, 9) < 2) begin
      it.src_x = $urandom;
      it.src_y = $urandom;
      it.src_depth = $urandom;
      it.obs_x = $urandom;
      it.obs_y = $urandom;
    end else begin
      it.src_x = $urandom_range(0, 1 << 18) - (1 << 17);
      it.src_y = $urandom_range(0, 1 << 18) - (1 << 17);
      it.src_depth = ($urandom_range(0, 19) == 0) ? -$urandom_range(0, 1 << 16)
                                                  : $urandom_range(1 << 14, 1 << 22);
      it.obs_x = $urandom_range(0, 1 << 18) - (1 << 17);
      it.obs_y = $urandom_range(0, 1 << 18) - (1 << 17);
    end
    it.last_pair = last;
    return it;
  endfunction

  function automatic rea_in_t build_pair(input int sx, input int sy, input int sd,
                                         input int ox, input int oy, input bit last);
    rea_in_t it;
    it.src_x = sx;
    it.src_y = sy;
    it.src_depth = sd;
    it.obs_x = ox;
    it.obs_y = oy;
    it.last_pair = last;
    return it;
  endfunction

  task automatic wait_idle();
    while (totals_pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  initial begin
    int set_len;
    int left;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    idle_cycles = 0;
    pairs_sent = 0;
    calm = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset pose: raw-1 diagonal, so small depths project to zero depth
    send_pair(build_pair(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 0, 0, 1'b0));
    send_pair(build_pair(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 0, 0, 1'b1));
    wait_idle();

    // identity pose, plus writes to unused indexes that must be ignored
    load_pose(pack_row(Q18One, 0, 0), pack_row(0, Q18One, 0), pack_row(0, 0, Q18One), 0, 0, 0);
    write_reg(3'd6, {RowW{1'b1}});
    write_reg(3'd7, {RowW{1'b1}});
    end_cfg();
    send_pair(build_pair(0, 0, 32'h0001_0000, 0, 0, 1'b1));
    send_pair(build_pair(32'h0001_0000, 32'hffff_0000, 32'h0002_0000, 32'h7fff_ffff,
                         32'h8000_0000, 1'b0));
    send_pair(build_pair(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                         32'h8000_0000, 1'b0));
    send_pair(build_pair(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                         32'h7fff_ffff, 1'b1));
    send_pair(build_pair(32'h0001_0000, 32'h0001_0000, 0, 0, 0, 1'b0));
    send_pair(build_pair(32'h0001_0000, 32'h0001_0000, 32'h8000_0000, 0, 0, 1'b0));
    send_pair(build_pair(32'h0000_8000, 32'hffff_8000, 32'h0000_0001, 32'h0000_0001,
                         32'hffff_ffff, 1'b1));
    // lone closing item and tiny residual
    send_pair(build_pair(32'h0000_4000, 32'h0000_4000, 32'h0004_0000, 32'h0000_4000,
                         32'h0000_4001, 1'b1));
    wait_idle();

    // extreme poses: full positive and full negative entries, extreme translation
    load_pose(pack_row(32'h7ffff, 32'h7ffff, 32'h7ffff), pack_row(32'h7ffff, 32'h7ffff, 32'h7ffff),
              pack_row(32'h7ffff, 32'h7ffff, 32'h7ffff),
              32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
    send_pair(build_pair(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0, 1'b0));
    send_pair(build_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 1'b0));
    send_pair(build_pair(32'h0001_0000, 32'h0001_0000, 32'h0010_0000, 5, 5, 1'b1));
    wait_idle();
    load_pose(pack_row(32'h80000, 32'h80000, 32'h80000), pack_row(32'h80000, 32'h80000, 32'h80000),
              pack_row(32'h80000, 32'h80000, 32'h80000),
              32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
    send_pair(build_pair(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 0, 0, 1'b0));
    send_pair(build_pair(32'h0001_0000, 32'h0001_0000, 32'hfff0_0000, 0, 0, 1'b1));
    wait_idle();

    // random phases, each under its own pose, every phase closing its last set
    for (int ph = 0; ph < 16; ph++) begin
      if (ph == 0)
        load_pose(pack_row(Q18One, 0, 0), pack_row(0, Q18One, 0), pack_row(0, 0, Q18One),
                  0, 0, 32'hfff0_0000);
      else
        load_random_pose();
      calm = (ph % 5 == 2);
      left = 40;
      while (left > 0) begin
        set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 25) : $urandom_range(1, 6);
        if (set_len > left) set_len = left;
        for (int k = 0; k < set_len; k++) send_pair(random_pair(k == set_len - 1));
        left -= set_len;
      end
      calm = 1'b0;
      wait_idle();
    end

    $display("sent %0d correspondences, checked %0d totals (%0d with a depth fault)",
             pairs_sent, totals_checked, faults_seen);
    $display("poses covered: reset, identity, extreme entries and 15 random ones");
    if (fail_count == 0 && totals_pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[files.f]
sv/rea_pkg.sv
sv/rea_ctrl.sv
sv/rea_datapath.sv
sv/reprojection_error_accumulator_unit.sv
sim/reprojection_error_accumulator_checker.sv
sim/reprojection_error_accumulator_unit_test.sv
